/* sv/api_frame_receiver_defines.svh */
// assertion macros shared by the frame receiver rtl
// no dependencies; files that assert include this by bare name
`ifndef API_FRAME_RECEIVER_DEFINES_SVH
`define API_FRAME_RECEIVER_DEFINES_SVH

// checked while out of reset
`define AFR_ASSERT(name, prop, msg) \
  name: assert property (@(posedge clk) disable iff (rst) prop) else $error(msg);

// checked on every edge, reset included
`define AFR_ASSERT_ALWAYS(name, prop, msg) \
  name: assert property (@(posedge clk) prop) else $error(msg);

`endif

/* sv/afr_pkg.sv */
// types and constants for the api frame receiver
// no dependencies; used by the top level, the input and output registers and the parser
package afr_pkg;

  localparam logic [7:0] START_DELIM = 8'h7E;
  localparam logic [7:0] HEADER_LEN  = 8'd3;
  localparam logic [7:0] CHECK_BASE  = 8'hFF;
  localparam logic [7:0] IDX_LEN_HI  = 8'd1;
  localparam logic [7:0] IDX_LEN_LO  = 8'd2;

  // size of the frame store in bytes
  localparam int MAX_FRAME = 256;
  // highest index a checksum byte may have
  localparam int END_LIMIT = (MAX_FRAME - 1 < 255) ? MAX_FRAME - 1 : 255;

  typedef struct packed {
    logic [7:0] rx_byte;
  } in_item_t;

  typedef struct packed {
    logic [7:0] data_byte;
    logic [7:0] byte_index;
    logic       is_last;
    logic       checksum_ok;
    logic       length_error;
  } out_item_t;

endpackage

/* sv/afr_chan_if.sv */
// valid/ready channel carrying one item of a packed type
// depends on nothing; item types come from afr_pkg at instantiation
interface afr_chan_if #(
  parameter type item_t = logic [7:0]
);
  logic  valid;
  logic  ready;
  item_t payload;

  modport source (output valid, output payload, input ready);
  modport sink (input valid, input payload, output ready);
endinterface

/* sv/api_frame_receiver.sv */
// top level of the api frame receiver
// depends on afr_pkg, afr_chan_if, afr_in_reg, afr_parser, afr_out_reg
//
//   channel    dir  type        payload
//   rx_chan    in   in_item_t   rx_byte
//   frame_out  out  out_item_t  data_byte, byte_index, is_last,
//                               checksum_ok, length_error
//
// one byte per cycle sustained while frame_out is not stalled; a result goes
// through the input register, then parse logic into the output register
// reset (rst, synchronous) empties both registers and returns to delimiter hunt
// a stalled frame_out holds its item; rx_chan keeps accepting while the
// input register can move forward in the same cycle
module api_frame_receiver import afr_pkg::*; (
  input logic clk,
  input logic rst,
  afr_chan_if.sink   rx_chan,
  afr_chan_if.source frame_out
);

  // input register outputs
  logic       held_valid;
  logic [7:0] held_byte;

  // parse step and its result
  logic       step;
  logic       res_valid;
  out_item_t  res;
  logic       out_free;

  // the held byte is parsed whenever the output register has room,
  // dropped bytes included so the hunt never stalls without need
  assign step = held_valid && out_free;

  afr_in_reg u_in_reg (
    .clk        (clk),
    .rst        (rst),
    .in_valid   (rx_chan.valid),
    .in_byte    (rx_chan.payload.rx_byte),
    .in_ready   (rx_chan.ready),
    .take       (step),
    .held_valid (held_valid),
    .held_byte  (held_byte)
  );

  afr_parser u_parser (
    .clk        (clk),
    .rst        (rst),
    .step       (step),
    .byte_valid (held_valid),
    .rx_byte    (held_byte),
    .res_valid  (res_valid),
    .res        (res)
  );

  // only bytes that produce an item are loaded
  afr_out_reg u_out_reg (
    .clk       (clk),
    .rst       (rst),
    .load      (step && res_valid),
    .load_item (res),
    .free      (out_free),
    .out_valid (frame_out.valid),
    .out_ready (frame_out.ready),
    .out_item  (frame_out.payload)
  );

endmodule

/* sv/afr_in_reg.sv */
// input register: holds one received byte until the parser takes it
// depends on afr_pkg
module afr_in_reg import afr_pkg::*; (
  input  logic       clk,
  input  logic       rst,
  input  logic       in_valid,
  input  logic [7:0] in_byte,
  output logic       in_ready,
  input  logic       take,
  output logic       held_valid,
  output logic [7:0] held_byte
);

  // free when empty or emptied in this cycle
  assign in_ready = !held_valid || take;

  always_ff @(posedge clk) begin
    if (rst) begin
      held_valid <= 1'b0;
    end else if (in_ready) begin
      held_valid <= in_valid;
    end
    if (in_ready && in_valid) begin
      held_byte <= in_byte;
    end
  end

endmodule

/* sv/afr_parser.sv */
// frame parser: delimiter hunt, length capture, payload sum, checksum check
// depends on afr_pkg and api_frame_receiver_defines.svh
`include "api_frame_receiver_defines.svh"

module afr_parser import afr_pkg::*; (
  input  logic       clk,
  input  logic       rst,
  input  logic       step,
  input  logic       byte_valid,
  input  logic [7:0] rx_byte,
  output logic       res_valid,
  output out_item_t  res
);

  logic       in_frame;
  logic [7:0] position;
  logic [7:0] length_high;
  logic [7:0] end_position;
  logic [7:0] running_sum;

  logic       in_frame_next;
  logic [7:0] position_next;
  logic [7:0] length_high_next;
  logic [7:0] end_position_next;
  logic [7:0] running_sum_next;

  logic [7:0]  idx;
  logic [16:0] frame_end;
  logic        go_idle;

  assign idx       = position + 8'd1;
  assign frame_end = {1'b0, length_high, rx_byte} + {9'd0, HEADER_LEN};

  always_comb begin
    in_frame_next     = in_frame;
    position_next     = position;
    length_high_next  = length_high;
    end_position_next = end_position;
    running_sum_next  = running_sum;
    go_idle           = 1'b0;
    res_valid         = 1'b0;
    res.data_byte     = rx_byte;
    res.byte_index    = idx;
    res.is_last       = 1'b0;
    res.checksum_ok   = 1'b0;
    res.length_error  = 1'b0;

    if (!in_frame) begin
      res.byte_index = 8'd0;
      if (rx_byte == START_DELIM) begin
        res_valid     = byte_valid;
        go_idle       = 1'b1;
        in_frame_next = 1'b1;
      end
    end else begin
      res_valid     = byte_valid;
      position_next = idx;
      priority if (idx == IDX_LEN_HI) begin
        length_high_next = rx_byte;
      end else if (idx == IDX_LEN_LO) begin
        if (frame_end > 17'(END_LIMIT)) begin
          res.is_last      = 1'b1;
          res.length_error = 1'b1;
          go_idle          = 1'b1;
        end else begin
          end_position_next = frame_end[7:0];
        end
      end else if (idx == end_position) begin
        res.is_last     = 1'b1;
        res.checksum_ok = (rx_byte == (CHECK_BASE - running_sum));
        go_idle         = 1'b1;
      end else if (idx >= HEADER_LEN) begin
        running_sum_next = running_sum + rx_byte;
      end else begin
        running_sum_next = running_sum;
      end
    end

    if (go_idle) begin
      position_next     = 8'd0;
      length_high_next  = 8'd0;
      end_position_next = 8'hFF;
      running_sum_next  = 8'd0;
      if (in_frame) begin
        in_frame_next = 1'b0;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      in_frame     <= 1'b0;
      position     <= 8'd0;
      length_high  <= 8'd0;
      end_position <= 8'hFF;
      running_sum  <= 8'd0;
    end else if (step) begin
      in_frame     <= in_frame_next;
      position     <= position_next;
      length_high  <= length_high_next;
      end_position <= end_position_next;
      running_sum  <= running_sum_next;
    end
  end

  `AFR_ASSERT(a_err_is_last, res_valid && res.length_error |-> res.is_last, "length error without frame end")
  `AFR_ASSERT(a_ok_is_last, res_valid && res.checksum_ok |-> res.is_last, "checksum flag off the last byte")
  `AFR_ASSERT(a_idle_after_last, step && res_valid && res.is_last |=> !in_frame, "frame still open after its last byte")
  `AFR_ASSERT(a_index0_delim, res_valid && res.byte_index == 8'd0 |-> res.data_byte == START_DELIM, "index zero on a non delimiter")

endmodule

/* sv/afr_out_reg.sv */
// output register: holds one result item until the sink takes it
// depends on afr_pkg
module afr_out_reg import afr_pkg::*; (
  input  logic      clk,
  input  logic      rst,
  input  logic      load,
  input  out_item_t load_item,
  output logic      free,
  output logic      out_valid,
  input  logic      out_ready,
  output out_item_t out_item
);

  assign free = !out_valid || out_ready;

  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (load) begin
      out_valid <= 1'b1;
    end else if (out_ready) begin
      out_valid <= 1'b0;
    end
    if (load) begin
      out_item <= load_item;
    end
  end

endmodule

/* tb/tb.sv */
// self-checking testbench for api_frame_receiver: a directed table, then random frames
// depends on afr_pkg, afr_chan_if and the api_frame_receiver rtl
module tb;
  timeunit 1ns;
  timeprecision 1ps;
  import afr_pkg::*;

  // how a stimulus row's result is checked
  typedef enum logic [1:0] {
    CHK_MODEL,   // expectation comes from the frame predictor
    CHK_SILENT,  // the byte must produce nothing
    CHK_FIXED    // expectation typed into the table
  } check_t;

  typedef struct {
    logic [7:0] rx_byte;
    check_t     chk;
    out_item_t  want;
  } stim_row_t;

  // receiver stall patterns
  typedef enum logic [1:0] {RDY_OPEN, RDY_COIN, RDY_BEAT} ready_mode_t;

  localparam int RANDOM_ITEMS = 600;

  logic clk;
  logic rst;

  afr_chan_if #(.item_t(in_item_t))  rx_chan ();
  afr_chan_if #(.item_t(out_item_t)) frame_out ();

  api_frame_receiver dut (
    .clk       (clk),
    .rst       (rst),
    .rx_chan   (rx_chan),
    .frame_out (frame_out)
  );

  // directed table: idle noise, zero length good and bad checksum, length
  // overruns (just over the limit, all ones, 256), delimiter inside a frame
  // fixed expectations are packed as {data, index, last, ok, length_error}
  stim_row_t directed_rows [26] = '{
    '{8'h00, CHK_SILENT, '0},
    '{8'hFF, CHK_SILENT, '0},
    '{8'h7E, CHK_FIXED,  {8'h7E, 8'd0, 1'b0, 1'b0, 1'b0}},
    '{8'h00, CHK_FIXED,  {8'h00, 8'd1, 1'b0, 1'b0, 1'b0}},
    '{8'h00, CHK_FIXED,  {8'h00, 8'd2, 1'b0, 1'b0, 1'b0}},
    '{8'hFF, CHK_FIXED,  {8'hFF, 8'd3, 1'b1, 1'b1, 1'b0}},
    '{8'h7E, CHK_FIXED,  {8'h7E, 8'd0, 1'b0, 1'b0, 1'b0}},
    '{8'h00, CHK_FIXED,  {8'h00, 8'd1, 1'b0, 1'b0, 1'b0}},
    '{8'h00, CHK_FIXED,  {8'h00, 8'd2, 1'b0, 1'b0, 1'b0}},
    '{8'h00, CHK_FIXED,  {8'h00, 8'd3, 1'b1, 1'b0, 1'b0}},
    '{8'h7E, CHK_FIXED,  {8'h7E, 8'd0, 1'b0, 1'b0, 1'b0}},
    '{8'h00, CHK_FIXED,  {8'h00, 8'd1, 1'b0, 1'b0, 1'b0}},
    '{8'hFD, CHK_FIXED,  {8'hFD, 8'd2, 1'b1, 1'b0, 1'b1}},
    '{8'h7E, CHK_FIXED,  {8'h7E, 8'd0, 1'b0, 1'b0, 1'b0}},
    '{8'hFF, CHK_FIXED,  {8'hFF, 8'd1, 1'b0, 1'b0, 1'b0}},
    '{8'hFF, CHK_FIXED,  {8'hFF, 8'd2, 1'b1, 1'b0, 1'b1}},
    '{8'h7E, CHK_MODEL,  '0},
    '{8'h01, CHK_MODEL,  '0},
    '{8'h00, CHK_FIXED,  {8'h00, 8'd2, 1'b1, 1'b0, 1'b1}},
    '{8'h7E, CHK_MODEL,  '0},
    '{8'h00, CHK_MODEL,  '0},
    '{8'h03, CHK_MODEL,  '0},
    '{8'h7E, CHK_MODEL,  '0},
    '{8'hFF, CHK_MODEL,  '0},
    '{8'h01, CHK_MODEL,  '0},
    '{8'h81, CHK_MODEL,  '0}
  };

  // predictor state: a copy of the receiver's frame tracking
  logic       frame_open;
  logic [7:0] frame_pos;
  logic [7:0] len_high;
  logic [7:0] check_pos;
  logic [7:0] payload_sum;

  out_item_t expected_bytes [$];
  int        frame_bytes_taken = 0;
  int        failures = 0;

  // how the byte currently on rx_chan is to be checked
  check_t    row_check;
  out_item_t row_result;

  // sender burst bookkeeping
  int burst_left = 0;

  // receiver stall pattern bookkeeping
  ready_mode_t ready_mode = RDY_OPEN;
  int          mode_left = 0;
  int          beat_len = 2;
  int          beat_cnt = 0;

  initial begin
    clk = 1'b0;
    forever #10 clk = ~clk;
  end

  // back to delimiter hunt
  function automatic void reset_frame();
    frame_open  = 1'b0;
    frame_pos   = 8'd0;
    len_high    = 8'd0;
    check_pos   = 8'hFF;
    payload_sum = 8'd0;
  endfunction

  // works out what one received byte produces; returns 1 if it gives a result
  function automatic logic predict_frame_byte(input logic [7:0] b, output out_item_t r);
    logic [7:0] idx;
    int         end_at;
    r = '0;
    r.data_byte = b;
    // hunting: only a delimiter opens a frame
    if (!frame_open) begin
      if (b != START_DELIM) return 1'b0;
      reset_frame();
      frame_open = 1'b1;
      return 1'b1;
    end
    idx = frame_pos + 8'd1;
    frame_pos = idx;
    r.byte_index = idx;
    if (idx == IDX_LEN_HI) begin
      len_high = b;
    end else if (idx == IDX_LEN_LO) begin
      end_at = int'({len_high, b}) + int'(HEADER_LEN);
      // checksum index past the store or past 8 bits: abort on this byte
      if (end_at > END_LIMIT) begin
        r.is_last = 1'b1;
        r.length_error = 1'b1;
        reset_frame();
      end else begin
        check_pos = end_at[7:0];
      end
    end else if (idx == check_pos) begin
      r.is_last = 1'b1;
      r.checksum_ok = (b == CHECK_BASE - payload_sum);
      reset_frame();
    end else if (idx >= HEADER_LEN) begin
      // payload, a delimiter in here is plain data
      payload_sum = payload_sum + b;
    end
    return 1'b1;
  endfunction

  function automatic void check_field(string name, logic [7:0] want, logic [7:0] got);
    if (got !== want) begin
      $error("%s: expected %0h, got %0h", name, want, got);
      failures++;
    end
  endfunction

  initial reset_frame();

  // sampling at the rising edge: inputs were set at the falling edge, so
  // everything read here is settled and the dut's own updates are not yet applied
  always @(posedge clk) begin
    out_item_t  model;
    out_item_t  want;
    out_item_t  got;
    logic       produced;
    if (!rst) begin
      // an accepted byte advances the predictor and queues its expectation
      if (rx_chan.valid && rx_chan.ready) begin
        produced = predict_frame_byte(rx_chan.payload.rx_byte, model);
        if (produced) frame_bytes_taken++;
        if (row_check == CHK_FIXED) expected_bytes.push_back(row_result);
        else if (row_check == CHK_MODEL && produced) expected_bytes.push_back(model);
      end
      // an accepted result is checked against the oldest expectation
      if (frame_out.valid && frame_out.ready) begin
        got = frame_out.payload;
        if (expected_bytes.size() == 0) begin
          $error("unexpected result: data_byte %0h byte_index %0d", got.data_byte,
                 got.byte_index);
          failures++;
        end else begin
          want = expected_bytes.pop_front();
          check_field("data_byte", want.data_byte, got.data_byte);
          check_field("byte_index", want.byte_index, got.byte_index);
          check_field("is_last", 8'(want.is_last), 8'(got.is_last));
          check_field("checksum_ok", 8'(want.checksum_ok), 8'(got.checksum_ok));
          check_field("length_error", 8'(want.length_error), 8'(got.length_error));
        end
      end
    end
  end

  // receiver: switches among always ready, coin flips and a periodic stall
  initial begin
    frame_out.ready = 1'b0;
    forever begin
      @(negedge clk);
      if (mode_left == 0) begin
        ready_mode = ready_mode_t'($urandom_range(0, 2));
        mode_left  = $urandom_range(32, 128);
        beat_len   = $urandom_range(2, 5);
      end
      mode_left--;
      beat_cnt++;
      case (ready_mode)
        RDY_OPEN: frame_out.ready = 1'b1;
        RDY_COIN: frame_out.ready = 1'($urandom_range(0, 1));
        default:  frame_out.ready = (beat_cnt % beat_len) != 0;
      endcase
    end
  end

  // sender: bursts of random length with random gaps, sometimes long runs
  // called and returning at a falling edge; holds the byte until taken
  task automatic send_byte(input logic [7:0] b, input check_t chk, input out_item_t want);
    if (burst_left == 0) begin
      rx_chan.valid = 1'b0;
      repeat ($urandom_range(1, 6)) @(negedge clk);
      burst_left = ($urandom_range(0, 9) == 0) ? $urandom_range(40, 120)
                                               : $urandom_range(1, 16);
    end
    burst_left--;
    rx_chan.valid = 1'b1;
    rx_chan.payload.rx_byte = b;
    row_check  = chk;
    row_result = want;
    do @(posedge clk); while (!rx_chan.ready);
    @(negedge clk);
  endtask

  // pause the sender until every expected result has come back
  task automatic wait_drained();
    rx_chan.valid = 1'b0;
    burst_left = 0;
    while (expected_bytes.size() != 0) @(negedge clk);
  endtask

  // one frame with random content; mostly well formed, sometimes an overrun
  // length, a bad checksum or a byte count that disagrees with the header
  task automatic send_random_frame();
    int         pick;
    int         len;
    int         n_payload;
    logic [7:0] sum;
    logic [7:0] b;
    // line noise while hunting
    if ($urandom_range(0, 3) == 0)
      repeat ($urandom_range(1, 3)) send_byte(8'($urandom_range(0, 255)), CHK_MODEL, '0);
    pick = $urandom_range(0, 99);
    if (pick < 70)      len = $urandom_range(0, 12);
    else if (pick < 82) len = $urandom_range(13, 60);
    else if (pick < 84) len = END_LIMIT - int'(HEADER_LEN);  // longest legal frame
    else if (pick < 93) len = $urandom_range(END_LIMIT - int'(HEADER_LEN) + 1, 300);
    else                len = ($urandom_range(1, 255) << 8) | $urandom_range(0, 255);
    send_byte(START_DELIM, CHK_MODEL, '0);
    send_byte(len[15:8], CHK_MODEL, '0);
    send_byte(len[7:0], CHK_MODEL, '0);
    if (len + int'(HEADER_LEN) > END_LIMIT) return;
    n_payload = len;
    if ($urandom_range(0, 19) == 0) n_payload = $urandom_range(0, len + 4);
    sum = 8'd0;
    repeat (n_payload) begin
      b = ($urandom_range(0, 9) == 0) ? START_DELIM : 8'($urandom_range(0, 255));
      sum = sum + b;
      send_byte(b, CHK_MODEL, '0);
    end
    b = ($urandom_range(0, 3) != 0) ? CHECK_BASE - sum : 8'($urandom_range(0, 255));
    send_byte(b, CHK_MODEL, '0);
  endtask

  initial begin
    rst = 1'b1;
    rx_chan.valid = 1'b0;
    rx_chan.payload = '0;
    row_check  = CHK_MODEL;
    row_result = '0;
    repeat (9) @(posedge clk);
    @(negedge clk);
    rst = 1'b0;

    foreach (directed_rows[i])
      send_byte(directed_rows[i].rx_byte, directed_rows[i].chk, directed_rows[i].want);
    wait_drained();

    // random part, with an occasional full drain before a frame
    while (frame_bytes_taken < RANDOM_ITEMS + $size(directed_rows)) begin
      if ($urandom_range(0, 24) == 0) wait_drained();
      send_random_frame();
    end
    wait_drained();
    // time for anything stray to show up
    repeat (8) @(posedge clk);

    if (failures == 0) $display("== PASS ==");
    else $display("== FAIL ==");
    $finish;
  end

  // hang guard, far beyond the slowest legal run
  initial begin
    #5_000_000;
    $display("== FAIL ==");
    $finish;
  end

endmodule
